// File: rtl/rsc_pkg.sv
// Shared types and constants of the RPN stack calculator.
package rsc_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int VAR_COUNT       = 27;
    localparam int LAST_PRINTED    = 26;
    localparam int VAR_AW          = $clog2(VAR_COUNT);
    localparam int DIV_DVD_W       = 48;
    localparam int DIV_DVS_W       = 32;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] operand_value;
        logic [4:0]         variable_index;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               value_valid;
        logic [2:0]         status;
    } out_beat_t;

    typedef enum logic [3:0] {
        MODE_PUSH_NUM = 4'd0,
        MODE_PUSH_VAR = 4'd1,
        MODE_ASSIGN   = 4'd2,
        MODE_ADD      = 4'd3,
        MODE_SUB      = 4'd4,
        MODE_MUL      = 4'd5,
        MODE_DIV      = 4'd6,
        MODE_MOD      = 4'd7,
        MODE_PEEK     = 4'd8,
        MODE_DUP      = 4'd9,
        MODE_SWAP     = 4'd10,
        MODE_CLEAR    = 4'd11,
        MODE_PRINT    = 4'd12
    } mode_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_EMPTY    = 3'd1,
        STS_FULL     = 3'd2,
        STS_ZERO_DIV = 3'd3,
        STS_BAD_VAR  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_WR1,
        S_WR2,
        S_DONE
    } state_t;

endpackage

// File: rtl/rsc_ram.sv
// Generic simple dual-port RAM with registered read.
module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/rsc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rsc_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [rsc_pkg::DIV_DVD_W-1:0]  dividend,
    input  logic [rsc_pkg::DIV_DVS_W-1:0]  divisor,
    output logic                           done,
    output logic [rsc_pkg::DIV_DVD_W-1:0]  quotient,
    output logic [rsc_pkg::DIV_DVS_W-1:0]  remainder
);
    import rsc_pkg::*;

    localparam int CW = $clog2(DIV_DVD_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [DIV_DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_DVS_W:0]   rem_reg, rem_next;
    logic [DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [DIV_DVS_W:0]   rem_sh;
    logic [DIV_DVS_W+1:0] diff;

    always_comb begin
        rem_sh    = {rem_reg[DIV_DVS_W-1:0], quo_reg[DIV_DVD_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DIV_DVS_W+1]) begin
                rem_next = diff[DIV_DVS_W:0];
                quo_next = {quo_reg[DIV_DVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIV_DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DIV_DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DIV_DVS_W-1:0];

endmodule

// File: rtl/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: sequencer, stack and variable memories.
//
//  channel | dir | ports                    | beat
//  --------+-----+--------------------------+-------------------------------
//  s_      | in  | s_valid s_ready s_data   | command: mode, operand, var idx
//  m_      | out | m_valid m_ready m_data   | result, value_valid, status
//
// Per command: accept, two stack reads, execute, one stack write (two for swap,
// none for peek, clear, assign, print, a failed push or a zero divisor),
// output load; multiply adds a saturation state, divide and modulo wait on the
// 48-step shared divider. Synchronous active-low reset; the stack memory is not
// cleared and the variable store reads zero through per-entry valid bits. One
// command is in flight at a time; a result waiting in the output register
// does not block the next command until that command's own result is ready.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rsc_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rsc_pkg::out_beat_t m_data
);
    import rsc_pkg::*;

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] DEPTH_SP = SP_W'(STACK_DEPTH);

    // ---------------------------------------------------------------- state
    state_t           state_reg, state_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    in_beat_t         cmd_reg, cmd_next;
    logic signed [31:0] top_reg, top_next;   // stack[sp-1]
    logic signed [31:0] sec_reg, sec_next;   // stack[sp-2]
    logic signed [31:0] var_reg, var_next;
    logic signed [63:0] prod_reg, prod_next;
    logic             neg_reg, neg_next;
    logic [IDX_W-1:0] push_addr_reg, push_addr_next;
    logic signed [31:0] push_val_reg, push_val_next;
    logic signed [31:0] push2_val_reg, push2_val_next;
    logic             swap_reg, swap_next;
    out_beat_t        res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_data_reg, m_data_next;
    logic [VAR_COUNT-1:0] var_vld_reg, var_vld_next;

    // ------------------------------------------------------------ memories
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr, stk_raddr;
    logic [31:0]      stk_wdata, stk_rdata;
    logic             var_we;
    logic [VAR_AW-1:0] var_waddr, var_raddr;
    logic [31:0]      var_wdata, var_rdata;

    // ------------------------------------------------------------- divider
    logic                 div_start, div_done;
    logic [DIV_DVD_W-1:0] div_dvd, div_quo;
    logic [DIV_DVS_W-1:0] div_dvs, div_rem;

    // ------------------------------------------------------ execute helpers
    logic             has1, has2;
    logic [SP_W-1:0]  sp_dec1, sp_dec2, sp_m1, sp_m2;
    logic signed [31:0] a_pop, b_pop;
    logic signed [15:0] a_int, b_int;
    logic [31:0]      a_abs, b_abs;
    logic [15:0]      a_int_abs, b_int_abs;
    logic             vi_in_ok;

    function automatic logic signed [31:0] sat_addsub(input logic signed [31:0] a,
                                                      input logic signed [31:0] b,
                                                      input logic sub);
        logic signed [32:0] s;
        s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
        if (s[32] != s[31]) begin
            return s[32] ? Q_MIN : Q_MAX;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] mul_sat(input logic signed [63:0] p);
        // floor(p / 2^16) is p[63:16]; it fits when p[63:47] is all one sign
        if ((&p[63:47]) || !(|p[63:47])) begin
            return p[47:16];
        end
        return p[63] ? Q_MIN : Q_MAX;
    endfunction

    function automatic logic signed [15:0] int_part(input logic signed [31:0] v);
        // truncate toward zero
        return v[31:16] + {15'd0, v[31] && (v[15:0] != 16'd0)};
    endfunction

    rsc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    rsc_ram #(.WIDTH(32), .DEPTH(VAR_COUNT)) u_var_ram (
        .aclk  (aclk),
        .we    (var_we),
        .waddr (var_waddr),
        .wdata (var_wdata),
        .raddr (var_raddr),
        .rdata (var_rdata)
    );

    rsc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Read addresses: top in the accept cycle, second entry in the cycle after.
    // Writes of a command finish before the next command is accepted, so a
    // read never meets a pending write to the same entry.
    assign sp_dec1   = sp_reg - SP_W'(1);
    assign sp_dec2   = sp_reg - SP_W'(2);
    assign stk_raddr = (state_reg == S_RD1) ? sp_dec2[IDX_W-1:0] : sp_dec1[IDX_W-1:0];
    assign vi_in_ok  = (s_data.variable_index < 5'(VAR_COUNT));
    assign var_raddr = vi_in_ok ? VAR_AW'(s_data.variable_index) : '0;

    assign has1  = (sp_reg != '0);
    assign has2  = (sp_reg > SP_W'(1));
    assign sp_m1 = has1 ? sp_dec1 : '0;
    assign sp_m2 = has2 ? sp_dec2 : '0;
    assign b_pop = has1 ? top_reg : '0;      // first popped
    assign a_pop = has2 ? sec_reg : '0;      // second popped
    assign a_int = int_part(a_pop);
    assign b_int = int_part(b_pop);
    assign a_abs = a_pop[31] ? 32'(-a_pop) : 32'(a_pop);
    assign b_abs = b_pop[31] ? 32'(-b_pop) : 32'(b_pop);
    assign a_int_abs = a_int[15] ? 16'(-a_int) : 16'(a_int);
    assign b_int_abs = b_int[15] ? 16'(-b_int) : 16'(b_int);

    always_comb begin
        logic [DIV_DVD_W-1:0] q;
        logic [31:0]          mval;
        state_next     = state_reg;
        sp_next        = sp_reg;
        cmd_next       = cmd_reg;
        top_next       = top_reg;
        sec_next       = sec_reg;
        var_next       = var_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        push_addr_next = push_addr_reg;
        push_val_next  = push_val_reg;
        push2_val_next = push2_val_reg;
        swap_next      = swap_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        var_vld_next   = var_vld_reg;
        stk_we         = 1'b0;
        stk_waddr      = push_addr_reg;
        stk_wdata      = push_val_reg;
        var_we         = 1'b0;
        var_waddr      = VAR_AW'(cmd_reg.variable_index);
        var_wdata      = b_pop;
        div_start      = 1'b0;
        div_dvd        = {a_abs, 16'd0};
        div_dvs        = b_abs;
        q              = div_quo;
        mval           = {div_rem[15:0], 16'd0};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data;
                    state_next = S_RD1;
                end
            end
            S_RD1: begin
                top_next = stk_rdata;
                var_next = ((cmd_reg.variable_index < 5'(VAR_COUNT)) &&
                            var_vld_reg[VAR_AW'(cmd_reg.variable_index)]) ?
                           var_rdata : '0;
                state_next = S_RD2;
            end
            S_RD2: begin
                sec_next   = stk_rdata;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                res_next   = '{result_value: '0, value_valid: 1'b0, status: STS_OK};
                swap_next  = 1'b0;
                state_next = S_DONE;
                case (cmd_reg.mode)
                    MODE_PUSH_NUM, MODE_PUSH_VAR, MODE_DUP: begin
                        if (cmd_reg.mode == MODE_PUSH_VAR &&
                            cmd_reg.variable_index > 5'(LAST_PRINTED)) begin
                            res_next.status = STS_BAD_VAR;
                        end else if (cmd_reg.mode == MODE_DUP && !has1) begin
                            res_next.status = STS_EMPTY;
                        end else if (sp_reg == DEPTH_SP) begin
                            res_next.status = STS_FULL;
                        end else begin
                            push_addr_next = sp_reg[IDX_W-1:0];
                            case (cmd_reg.mode)
                                MODE_PUSH_NUM: push_val_next = cmd_reg.operand_value;
                                MODE_PUSH_VAR: push_val_next = var_reg;
                                default:       push_val_next = top_reg;
                            endcase
                            sp_next    = sp_reg + SP_W'(1);
                            state_next = S_WR1;
                        end
                    end
                    MODE_ASSIGN, MODE_PRINT: begin
                        if (cmd_reg.mode == MODE_ASSIGN &&
                            cmd_reg.variable_index >= 5'(LAST_PRINTED)) begin
                            res_next.status = STS_BAD_VAR;
                        end else begin
                            var_we    = 1'b1;
                            var_waddr = (cmd_reg.mode == MODE_PRINT) ?
                                        VAR_AW'(LAST_PRINTED) :
                                        VAR_AW'(cmd_reg.variable_index);
                            var_vld_next[var_waddr] = 1'b1;
                            res_next.result_value   = b_pop;
                            res_next.value_valid    = 1'b1;
                            res_next.status         = has1 ? STS_OK : STS_EMPTY;
                            sp_next                 = sp_m1;
                        end
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_SWAP: begin
                        res_next.status = has2 ? STS_OK : STS_EMPTY;
                        push_addr_next  = sp_m2[IDX_W-1:0];
                        push_val_next   = sat_addsub(a_pop, b_pop, cmd_reg.mode == MODE_SUB);
                        sp_next         = sp_m2 + SP_W'(1);
                        state_next      = S_WR1;
                        if (cmd_reg.mode == MODE_MUL) begin
                            prod_next  = a_pop * b_pop;
                            state_next = S_MUL;
                        end else if (cmd_reg.mode == MODE_SWAP) begin
                            // first popped goes back in first
                            push_val_next  = b_pop;
                            push2_val_next = a_pop;
                            swap_next      = 1'b1;
                            sp_next        = sp_m2 + SP_W'(2);
                        end
                    end
                    MODE_DIV, MODE_MOD: begin
                        if ((cmd_reg.mode == MODE_DIV && b_pop == '0) ||
                            (cmd_reg.mode == MODE_MOD && b_int == '0)) begin
                            // zero divisor: divisor popped, dividend kept
                            res_next.status = has1 ? STS_ZERO_DIV : STS_EMPTY;
                            sp_next         = sp_m1;
                        end else begin
                            res_next.status = has2 ? STS_OK : STS_EMPTY;
                            push_addr_next  = sp_m2[IDX_W-1:0];
                            sp_next         = sp_m2 + SP_W'(1);
                            div_start       = 1'b1;
                            if (cmd_reg.mode == MODE_DIV) begin
                                neg_next = a_pop[31] ^ b_pop[31];
                            end else begin
                                div_dvd  = {32'd0, a_int_abs};
                                div_dvs  = {16'd0, b_int_abs};
                                neg_next = a_int[15];
                            end
                            state_next = S_DIV;
                        end
                    end
                    MODE_PEEK: begin
                        if (has1) begin
                            res_next.result_value = top_reg;
                            res_next.value_valid  = 1'b1;
                        end else begin
                            res_next.status = STS_EMPTY;
                        end
                    end
                    MODE_CLEAR: begin
                        sp_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                push_val_next = mul_sat(prod_reg);
                state_next    = S_WR1;
            end
            S_DIV: begin
                if (div_done) begin
                    if (cmd_reg.mode == MODE_DIV) begin
                        if (!neg_reg) begin
                            push_val_next = (|q[DIV_DVD_W-1:31]) ? Q_MAX : q[31:0];
                        end else begin
                            push_val_next = (q > DIV_DVD_W'(33'h0_8000_0000)) ?
                                            Q_MIN : 32'(-q[31:0]);
                        end
                    end else begin
                        push_val_next = neg_reg ? 32'(-mval) : mval;
                    end
                    state_next = S_WR1;
                end
            end
            S_WR1: begin
                stk_we     = 1'b1;
                state_next = swap_reg ? S_WR2 : S_DONE;
            end
            S_WR2: begin
                stk_we     = 1'b1;
                stk_waddr  = push_addr_reg + IDX_W'(1);
                stk_wdata  = push2_val_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
            var_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
            var_vld_reg <= var_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        top_reg       <= top_next;
        sec_reg       <= sec_next;
        var_reg       <= var_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        push_addr_reg <= push_addr_next;
        push_val_reg  <= push_val_next;
        push2_val_reg <= push2_val_next;
        swap_reg      <= swap_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    // ----------------------------------------------------------- assertions
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= DEPTH_SP)
        else $error("stack pointer beyond depth");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside done state");

    a_sp_only_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_EXEC) |=> $stable(sp_reg))
        else $error("stack pointer moved outside execute");

endmodule
